>>> rtl/fr_pkg.sv
// Shared types and constants of the fragment reassembler.
// Used by every module in rtl; depends on nothing.
`default_nettype none
package fr_pkg;

  localparam int MsgDepthDef = 64;
  localparam int MaxAw       = 6;
  localparam int MaxPw       = 7;
  localparam int SizeW       = 6;
  localparam int QDepth      = 2;

  localparam int HdrStartBit = 7;
  localparam int HdrEndBit   = 6;
  localparam logic [7:0] HdrSizeMask = 8'h3F;

  localparam logic KindData   = 1'b0;
  localparam logic KindHeader = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       last;
    logic       overflow;
    logic       empty_res;
  } out_t;

  typedef struct packed {
    logic             do_write;
    logic [MaxAw-1:0] waddr;
    logic [7:0]       wdata;
    logic             do_emit;
    logic [MaxPw-1:0] elen;
    logic             eovf;
  } op_t;

endpackage
`default_nettype wire

>>> rtl/fr_front.sv
// Front end: accepts beats, tracks fragment state and turns beats into store
// writes and/or message emission commands. Depends on fr_pkg.
`default_nettype none
module fr_front #(
  parameter int MSG_DEPTH = fr_pkg::MsgDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire fr_pkg::in_t in_data_i,
  input  wire logic        q_full_i,
  output logic             q_push_o,
  output fr_pkg::op_t      q_op_o
);

  localparam int PW = $clog2(MSG_DEPTH + 1);

  logic [PW-1:0]            wpos_q, wpos_d;
  logic [fr_pkg::SizeW-1:0] rem_q, rem_d;
  logic                     endp_q, endp_d;
  logic                     ovf_q, ovf_d;
  logic                     accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    wpos_d   = wpos_q;
    rem_d    = rem_q;
    endp_d   = endp_q;
    ovf_d    = ovf_q;
    q_push_o = 1'b0;
    q_op_o   = '0;
    if (accept) begin
      if (in_data_i.kind == fr_pkg::KindHeader) begin
        if (in_data_i.rx_byte[fr_pkg::HdrStartBit]) begin
          wpos_d = '0;
          ovf_d  = 1'b0;
        end
        endp_d = in_data_i.rx_byte[fr_pkg::HdrEndBit];
        rem_d  = fr_pkg::SizeW'(in_data_i.rx_byte & fr_pkg::HdrSizeMask);
      end else if (rem_q != '0) begin
        if (wpos_q < PW'(MSG_DEPTH)) begin
          q_op_o.do_write = 1'b1;
          q_op_o.waddr    = fr_pkg::MaxAw'(wpos_q);
          q_op_o.wdata    = in_data_i.rx_byte;
          q_push_o        = 1'b1;
          wpos_d          = wpos_q + PW'(1);
        end else begin
          ovf_d = 1'b1;
        end
        rem_d = rem_q - fr_pkg::SizeW'(1);
      end
      if (rem_d == '0 && endp_d &&
          (in_data_i.kind == fr_pkg::KindHeader || rem_q != '0)) begin
        q_op_o.do_emit = 1'b1;
        q_op_o.elen    = fr_pkg::MaxPw'(wpos_d);
        q_op_o.eovf    = ovf_d;
        q_push_o       = 1'b1;
        wpos_d         = '0;
        endp_d         = 1'b0;
        ovf_d          = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpos_q <= '0;
      rem_q  <= '0;
      endp_q <= 1'b0;
      ovf_q  <= 1'b0;
    end else begin
      wpos_q <= wpos_d;
      rem_q  <= rem_d;
      endp_q <= endp_d;
      ovf_q  <= ovf_d;
    end
  end

endmodule
`default_nettype wire

>>> rtl/fr_fifo.sv
// Short command queue between the front end and the back end.
// Depends on fr_pkg for the command type and depth.
`default_nettype none
module fr_fifo (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire fr_pkg::op_t op_i,
  output logic             full_o,
  input  wire logic        pop_i,
  output logic             valid_o,
  output fr_pkg::op_t      op_o
);

  localparam int PtrW = $clog2(fr_pkg::QDepth);
  localparam int CntW = $clog2(fr_pkg::QDepth + 1);

  fr_pkg::op_t     mem_q [fr_pkg::QDepth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(fr_pkg::QDepth));
  assign valid_o = (cnt_q != '0);
  assign op_o    = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrW'(fr_pkg::QDepth - 1)) ? '0 : wptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrW'(fr_pkg::QDepth - 1)) ? '0 : rptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/fr_back.sv
// Back end: holds the message store, applies queued writes and emits
// completed messages one beat per cycle unless stalled. Depends on fr_pkg.
`default_nettype none
module fr_back #(
  parameter int MSG_DEPTH = fr_pkg::MsgDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        q_valid_i,
  input  wire fr_pkg::op_t q_op_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output fr_pkg::out_t     out_data_o
);

  localparam int AW = $clog2(MSG_DEPTH);
  localparam int PW = $clog2(MSG_DEPTH + 1);

  typedef enum logic {StIdle, StEmit} state_e;

  state_e        st_q;
  logic [7:0]    store [MSG_DEPTH];
  logic [7:0]    byte_q;
  logic [PW-1:0] rd_ptr_q, len_q, rd_nxt;
  logic          ovf_q;
  logic          out_vld_q, last_q, out_ovf_q, empty_q;
  logic          out_free, rd_en, empty_load, is_last;

  assign out_free   = !out_vld_q || !out_stall_i;
  assign q_pop_o    = (st_q == StIdle) && q_valid_i && (!q_op_i.do_emit || out_free);
  assign rd_en      = (st_q == StEmit) && out_free;
  assign empty_load = q_pop_o && q_op_i.do_emit && (q_op_i.elen[PW-1:0] == '0);
  assign rd_nxt     = rd_ptr_q + PW'(1);
  assign is_last    = (rd_nxt == len_q);

  always_ff @(posedge clk_i) begin
    if (q_pop_o && q_op_i.do_write) begin
      store[q_op_i.waddr[AW-1:0]] <= q_op_i.wdata;
    end
    if (rd_en) begin
      byte_q <= store[rd_ptr_q[AW-1:0]];
    end else if (empty_load) begin
      byte_q <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= StIdle;
      rd_ptr_q  <= '0;
      len_q     <= '0;
      ovf_q     <= 1'b0;
      out_vld_q <= 1'b0;
      last_q    <= 1'b0;
      out_ovf_q <= 1'b0;
      empty_q   <= 1'b0;
    end else begin
      if (empty_load || rd_en) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      case (st_q)
        StIdle: begin
          if (empty_load) begin
            last_q    <= 1'b1;
            out_ovf_q <= q_op_i.eovf;
            empty_q   <= 1'b1;
          end else if (q_pop_o && q_op_i.do_emit) begin
            st_q     <= StEmit;
            rd_ptr_q <= '0;
            len_q    <= q_op_i.elen[PW-1:0];
            ovf_q    <= q_op_i.eovf;
          end
        end
        StEmit: begin
          if (out_free) begin
            last_q    <= is_last;
            out_ovf_q <= ovf_q;
            empty_q   <= 1'b0;
            rd_ptr_q  <= rd_nxt;
            if (is_last) begin
              st_q <= StIdle;
            end
          end
        end
        default: begin
          st_q <= StIdle;
        end
      endcase
    end
  end

  assign out_valid_o          = out_vld_q;
  assign out_data_o.msg_byte  = byte_q;
  assign out_data_o.last      = last_q;
  assign out_data_o.overflow  = out_ovf_q;
  assign out_data_o.empty_res = empty_q;

endmodule
`default_nettype wire

>>> rtl/fragment_reassembler.sv
// Fragment reassembler top level: front end, two-entry command queue, back end.
// A completed message reaches the output through the command queue, the emit
// state and the output register; an empty message skips the emit state.
// Throughput: one input beat per cycle while the command queue has room; one
// output beat per cycle while not stalled, set by the single store read port.
// Reset clears all control state; the message store is not initialised.
`default_nettype none
module fragment_reassembler #(
  parameter int MSG_DEPTH = fr_pkg::MsgDepthDef
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire fr_pkg::in_t  in_data_i,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output fr_pkg::out_t      out_data_o
);

  logic        q_push, q_full, q_pop, q_valid;
  fr_pkg::op_t push_op, head_op;

  fr_front #(
    .MSG_DEPTH(MSG_DEPTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i (in_data_i),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_op_o    (push_op)
  );

  fr_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .op_i   (push_op),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .op_o   (head_op)
  );

  fr_back #(
    .MSG_DEPTH(MSG_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_op_i     (head_op),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full) else $error("Command pushed into a full queue.");

  a_pop_only_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("Command popped from an empty queue.");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_data_o.empty_res || out_data_o.last))
    else $error("Empty message beat without last flag.");
`endif

endmodule
`default_nettype wire

>>> tb/fragment_reassembler_checker.sv
// Checker for the fragment reassembler: watches both channels, predicts the
// message beats from the accepted fragment beats and compares them in order.
// Depends on fr_pkg for the beat types and header field positions.
module fragment_reassembler_checker #(
  parameter int MsgDepth = fr_pkg::MsgDepthDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic         in_stall_i,
  input  fr_pkg::in_t  in_data_i,
  input  logic         out_valid_i,
  input  logic         out_stall_i,
  input  fr_pkg::out_t out_data_i,
  output int           fail_count_o,
  output int           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0]   store_mirror [MsgDepth];
  int unsigned  fill_pos;
  logic [5:0]   still_due;
  logic         end_armed;
  logic         dropped_any;
  fr_pkg::out_t awaited_beats [$];

  task automatic release_message();
    fr_pkg::out_t beat;
    int unsigned  n;
    int unsigned  k;
    n = (fill_pos > MsgDepth) ? MsgDepth : fill_pos;
    if (n == 0) begin
      beat = '0;
      beat.last = 1'b1;
      beat.overflow = dropped_any;
      beat.empty_res = 1'b1;
      awaited_beats.push_back(beat);
    end else begin
      for (k = 0; k < n; k++) begin
        beat = '0;
        beat.msg_byte = store_mirror[k];
        beat.last = (k + 1 == n);
        beat.overflow = dropped_any;
        awaited_beats.push_back(beat);
      end
    end
    fill_pos = 0;
    end_armed = 1'b0;
    dropped_any = 1'b0;
  endtask

  task automatic absorb_beat(input fr_pkg::in_t beat);
    if (beat.kind == fr_pkg::KindHeader) begin
      if (beat.rx_byte[fr_pkg::HdrStartBit]) begin
        fill_pos = 0;
        dropped_any = 1'b0;
      end
      end_armed = beat.rx_byte[fr_pkg::HdrEndBit];
      still_due = 6'(beat.rx_byte & fr_pkg::HdrSizeMask);
      if (still_due == 0 && end_armed) begin
        release_message();
      end
    end else if (still_due != 0) begin
      if (fill_pos < MsgDepth) begin
        store_mirror[fill_pos] = beat.rx_byte;
        fill_pos++;
      end else begin
        dropped_any = 1'b1;
      end
      still_due--;
      if (still_due == 0 && end_armed) begin
        release_message();
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    fr_pkg::out_t want;
    if (!rst_ni) begin
      fill_pos = 0;
      still_due = '0;
      end_armed = 1'b0;
      dropped_any = 1'b0;
      awaited_beats.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (awaited_beats.size() == 0) begin
          $display("%0t: unexpected message beat, expected none,", $time,
                   " got byte %h last %b ovf %b empty %b",
                   out_data_i.msg_byte, out_data_i.last, out_data_i.overflow,
                   out_data_i.empty_res);
          fail_count_o++;
        end else begin
          want = awaited_beats.pop_front();
          if (out_data_i.msg_byte !== want.msg_byte || out_data_i.last !== want.last ||
              out_data_i.overflow !== want.overflow ||
              out_data_i.empty_res !== want.empty_res) begin
            $display("%0t: message beat mismatch,", $time,
                     " expected byte %h last %b ovf %b empty %b,",
                     want.msg_byte, want.last, want.overflow, want.empty_res,
                     " got byte %h last %b ovf %b empty %b",
                     out_data_i.msg_byte, out_data_i.last, out_data_i.overflow,
                     out_data_i.empty_res);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        absorb_beat(in_data_i);
      end
      pending_o = awaited_beats.size();
    end
  end

endmodule

>>> tb/fragment_reassembler_test.sv
// Top of the fragment reassembler testbench: clock, reset, fragment stimulus
// with random gaps and output stalls, and the final verdict.
// Depends on fr_pkg, fragment_reassembler and fragment_reassembler_checker.
module fragment_reassembler_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 200000;
  localparam int TargetBeats = 310;

  logic         clk_i;
  logic         rst_ni;
  logic         in_valid_i;
  logic         in_stall_o;
  fr_pkg::in_t  in_data_i;
  logic         out_valid_o;
  logic         out_stall_i;
  fr_pkg::out_t out_data_o;
  int           fail_count;
  int           pending;
  int           cycle_count = 0;
  int           beats_sent;
  bit           in_calm;
  bit           out_calm;

  fragment_reassembler dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  fragment_reassembler_checker reassembly_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_beat(input logic is_header, input logic [7:0] value);
    fr_pkg::in_t beat;
    int          gap;
    gap = in_calm ? 0 : $urandom_range(0, 10);
    beat.kind = is_header;
    beat.rx_byte = value;
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= beat;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    if ($urandom_range(0, 19) == 0) begin
      in_calm = ~in_calm;
    end
  endtask

  task automatic send_header(input logic [7:0] value);
    send_beat(fr_pkg::KindHeader, value);
    beats_sent++;
  endtask

  task automatic send_data(input logic [7:0] value);
    send_beat(fr_pkg::KindData, value);
    beats_sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic send_message(input bit force_big);
    int         mode;
    int         frags;
    int         f;
    int         size;
    int         j;
    bit         big;
    logic [7:0] hdr;
    mode = $urandom_range(0, 9);
    big = force_big || ($urandom_range(0, 11) == 0);
    frags = big ? $urandom_range(2, 3) : $urandom_range(1, 3);
    for (f = 0; f < frags; f++) begin
      size = big ? $urandom_range(20, 63) : $urandom_range(0, 6);
      hdr = 8'(size);
      hdr[fr_pkg::HdrStartBit] = (f == 0) && (mode != 1);
      hdr[fr_pkg::HdrEndBit] = (f == frags - 1);
      send_header(hdr);
      if (mode == 0 && size > 0) begin
        size = $urandom_range(0, size - 1);
      end
      for (j = 0; j < size; j++) begin
        send_data(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 9) == 0) begin
        send_beat(fr_pkg::KindData, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    out_stall_i = 1'b0;
    out_calm = 1'b0;
    wait (rst_ni);
    forever begin
      repeat (out_calm ? 0 : $urandom_range(0, 10)) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) begin
        @(posedge clk_i);
      end
      if ($urandom_range(0, 15) == 0) begin
        out_calm = ~out_calm;
      end
    end
  end

  initial begin
    bit drained_once;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    beats_sent = 0;
    in_calm = 1'b0;
    drained_once = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    send_beat(fr_pkg::KindData, 8'h77);
    send_header(8'hC0);
    send_header(8'hC3);
    send_data(8'h00);
    send_data(8'hFF);
    send_data(8'hA5);
    send_header(8'h81);
    send_data(8'h12);
    send_beat(fr_pkg::KindData, 8'h34);
    send_header(8'h41);
    send_data(8'h56);
    send_header(8'hC4);
    send_data(8'h01);
    send_header(8'h02);
    send_data(8'h02);
    send_data(8'h03);
    send_header(8'h40);
    send_header(8'h40);
    send_header(8'h3F);
    send_header(8'hBF);
    send_data(8'h5A);
    send_header(8'h80);

    send_message(1'b1);
    while (beats_sent < TargetBeats) begin
      if (!drained_once && beats_sent > TargetBeats / 2) begin
        drain();
        drained_once = 1'b1;
      end
      if ($urandom_range(0, 99) < 8) begin
        repeat ($urandom_range(1, 4)) begin
          send_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
          beats_sent++;
        end
      end else begin
        send_message(1'b0);
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
